@@ sv/hcd_pkg.sv @@
// shared types, constants and match tables for the cookie header detector
package hcd_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 65535;
	localparam int unsigned POS_W           = 16;
	localparam int unsigned CFG_W           = 16;
	localparam int unsigned MIN_LEN_RST     = 16;
	localparam int unsigned PAT_LEN         = 8;
	localparam int unsigned NUM_METH        = 3;
	localparam logic [7:0]  CR_BYTE         = 8'h0d;

	typedef enum logic [2:0] {
		ST_MATCH       = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_NO_METHOD   = 3'd2,
		ST_NO_HEADER   = 3'd3,
		ST_UNTERMINATED = 3'd4
	} status_t;

	typedef enum logic {
		REG_BLOCK_ENABLE = 1'b0,
		REG_MIN_LENGTH   = 1'b1
	} reg_index_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] value_offset;
		logic [POS_W-1:0] value_length;
		logic             rewrite;
	} result_t;

	function automatic logic [7:0] cookie_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h43;
			3'd1: c = 8'h6f;
			3'd2: c = 8'h6f;
			3'd3: c = 8'h6b;
			3'd4: c = 8'h69;
			3'd5: c = 8'h65;
			3'd6: c = 8'h3a;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] meth_len(input logic [1:0] m);
		logic [2:0] n;
		case (m)
			2'd0: n = 3'd4;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] meth_char(input logic [1:0] m, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		case (m)
			2'd0: begin
				case (idx)
					3'd0: c = 8'h47;
					3'd1: c = 8'h45;
					3'd2: c = 8'h54;
					3'd3: c = 8'h20;
					default: c = 8'h00;
				endcase
			end
			2'd1: begin
				case (idx)
					3'd0: c = 8'h50;
					3'd1: c = 8'h4f;
					3'd2: c = 8'h53;
					3'd3: c = 8'h54;
					3'd4: c = 8'h20;
					default: c = 8'h00;
				endcase
			end
			default: begin
				case (idx)
					3'd0: c = 8'h48;
					3'd1: c = 8'h45;
					3'd2: c = 8'h41;
					3'd3: c = 8'h44;
					3'd4: c = 8'h20;
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

@@ sv/hcd_match.sv @@
// per-packet scan state: method check, header search, value count and status
module hcd_match import hcd_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       byte_in,
	input  logic             last_in,
	input  logic             block_enable,
	input  logic [CFG_W-1:0] min_length,
	output result_t          result
);

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PAYLOAD);

	logic [POS_W-1:0]    pos_q;
	logic [NUM_METH-1:0] alive_q;
	logic [3:0]          prog_q;
	logic                found_q;
	logic                term_q;
	logic [POS_W-1:0]    off_q;
	logic [POS_W-1:0]    len_q;

	logic                active;
	logic [POS_W-1:0]    pos_n;
	logic [POS_W-1:0]    total;
	logic [NUM_METH-1:0] alive_n;
	logic [3:0]          prog_n;
	logic                found_n;
	logic                term_n;
	logic [POS_W-1:0]    off_n;
	logic [POS_W-1:0]    len_n;
	logic                method_ok;

	always_comb begin
		active  = pos_q < MAX_POS;
		pos_n   = pos_q;
		total   = MAX_POS;
		alive_n = alive_q;
		prog_n  = prog_q;
		found_n = found_q;
		term_n  = term_q;
		off_n   = off_q;
		len_n   = len_q;
		if (active) begin
			pos_n = pos_q + 1'b1;
			total = pos_q + 1'b1;
			for (int m = 0; m < NUM_METH; m++) begin
				if (pos_q < POS_W'(meth_len(2'(m))) &&
				    byte_in != meth_char(2'(m), pos_q[2:0]))
					alive_n[m] = 1'b0;
			end
			if (!found_q) begin
				if (byte_in == cookie_char(prog_q[2:0]))
					prog_n = prog_q + 1'b1;
				else
					prog_n = (byte_in == cookie_char(3'd0)) ? 4'd1 : 4'd0;
				if (prog_n == 4'(PAT_LEN)) begin
					found_n = 1'b1;
					off_n   = pos_q + 1'b1;
					prog_n  = 4'd0;
				end
			end else if (!term_q) begin
				if (byte_in == CR_BYTE)
					term_n = 1'b1;
				else
					len_n = len_q + 1'b1;
			end
		end
	end

	always_comb begin
		method_ok = 1'b0;
		for (int m = 0; m < NUM_METH; m++) begin
			if (alive_n[m] && total >= POS_W'(meth_len(2'(m))))
				method_ok = 1'b1;
		end
		result = '0;
		if (total < min_length)
			result.status = ST_TOO_SHORT;
		else if (!method_ok)
			result.status = ST_NO_METHOD;
		else if (!found_n)
			result.status = ST_NO_HEADER;
		else if (!term_n)
			result.status = ST_UNTERMINATED;
		else begin
			result.status       = ST_MATCH;
			result.value_offset = off_n;
			result.value_length = len_n;
			result.rewrite      = block_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= '1;
			prog_q  <= '0;
			found_q <= 1'b0;
			term_q  <= 1'b0;
			off_q   <= '0;
			len_q   <= '0;
		end else if (fire) begin
			if (last_in) begin
				pos_q   <= '0;
				alive_q <= '1;
				prog_q  <= '0;
				found_q <= 1'b0;
				term_q  <= 1'b0;
				off_q   <= '0;
				len_q   <= '0;
			end else begin
				pos_q   <= pos_n;
				alive_q <= alive_n;
				prog_q  <= prog_n;
				found_q <= found_n;
				term_q  <= term_n;
				off_q   <= off_n;
				len_q   <= len_n;
			end
		end
	end

	hdr_progress_a: assert property (@(posedge clk) disable iff (!arst_n)
		prog_q < 4'(PAT_LEN))
		else $error("header pattern progress out of range");

	term_needs_found_a: assert property (@(posedge clk) disable iff (!arst_n)
		term_q |-> found_q)
		else $error("terminator seen without header");

	pos_bound_a: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= MAX_POS)
		else $error("byte position beyond payload limit");

endmodule

@@ sv/http_cookie_header_detector.sv @@
// top level: input word register, packet scan and result register
// a last byte waits in the input word register until the result register is free, then its result is registered there
// throughput: one byte per cycle; the input stalls only when a result waits
//   in the output register and the output is stalled
// reset clears registers to block_enable 0, min_length 16, and an empty packet
module http_cookie_header_detector import hcd_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [POS_W-1:0] value_offset,
	output logic [POS_W-1:0] value_length,
	output logic             rewrite,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	logic             block_enable_q;
	logic [CFG_W-1:0] min_length_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic             out_valid_q;
	result_t          res_q;
	result_t          res_n;

	logic             out_free;
	logic             s1_fire;
	logic             res_load;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign res_load = s1_fire && last_s1;
	assign in_stall = valid_s1 && !s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_enable_q <= 1'b0;
			min_length_q   <= CFG_W'(MIN_LEN_RST);
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_BLOCK_ENABLE: block_enable_q <= wr_data[0];
				REG_MIN_LENGTH:   min_length_q   <= wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	hcd_match #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s1_fire),
		.byte_in      (byte_s1),
		.last_in      (last_s1),
		.block_enable (block_enable_q),
		.min_length   (min_length_q),
		.result       (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= res_load;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res_n;
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign value_offset = res_q.value_offset;
	assign value_length = res_q.value_length;
	assign rewrite      = res_q.rewrite;

	// a non-last word never waits on the output side
	mid_word_flows_a: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> s1_fire)
		else $error("non-last word held back");

	stall_cause_a: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without output back pressure");

	miss_fields_zero_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != ST_MATCH) |->
		(res_q.value_offset == '0 && res_q.value_length == '0 && !res_q.rewrite))
		else $error("nonzero fields on a miss result");

	rewrite_needs_enable_a: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_n.rewrite || block_enable_q))
		else $error("rewrite flagged with blocking disabled");

endmodule
